// ----- hdl/fkr_pkg.sv -----
// Shared types and sizes of the FIFO with keyed removal.
`timescale 1ns / 1ps

package fkr_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int HANDLE_BITS = 16;
   localparam int KEY_BITS    = 32;
   localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef logic [SLOT_BITS-1:0]   slot_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [HANDLE_BITS-1:0] handle_type;
   typedef logic [KEY_BITS-1:0]    key_type;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_TAKE   = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_FLUSH  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_NONE = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      handle_type handle;
      key_type    key;
      slot_type   next;
   } entry_type;

   localparam count_type DEPTH_COUNT = COUNT_BITS'(QUEUE_DEPTH);

endpackage

// ----- hdl/fkr_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module fkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hdl/fifo_with_keyed_removal_unit.sv -----
// Top level of the bounded descriptor FIFO with removal by key.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its single result appears on the rsp_
// ports for one cycle, flagged by rsp_strobe, and cannot be held off. Flush, a take or a remove
// on an empty queue and an add to a full queue answer in the cycle after the request is taken.
// A take answers from S_TAKE, after the head entry is read; an add into an empty queue answers
// from S_ADD_PLACE, and any other add goes on to S_ADD_LINK, as the tail entry is read back
// from the entry memory to link the new one. Remove-by-key walks the list one entry per cycle
// through the entry memory's read port, so it answers from the first matching entry from the
// head, or after the last held entry when none of them matches. Busy is already low in the cycle
// that the result is shown. Free slots are tracked by a stack and a high-water mark, so reset and
// flush need no clearing pass.

module fifo_with_keyed_removal_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_start,
   input  logic [1:0]           req_mode,
   input  fkr_pkg::handle_type  req_entry_handle,
   input  fkr_pkg::key_type     req_data_key,
   output logic                 busy,
   output logic                 rsp_strobe,
   output logic [1:0]           rsp_status,
   output fkr_pkg::handle_type  rsp_out_handle,
   output fkr_pkg::count_type   rsp_entry_count
);

   import fkr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_PLACE,
      S_ADD_LINK,
      S_TAKE,
      S_WALK
   } state_type;

   state_type  state_ff, state_in;
   slot_type   head_ff, head_in;
   slot_type   tail_ff, tail_in;
   count_type  count_ff, count_in;
   count_type  sp_ff, sp_in;
   count_type  hwm_ff, hwm_in;
   logic       pop_ff, pop_in;
   slot_type   slot_ff, slot_in;
   slot_type   cur_ff, cur_in;
   slot_type   prev_ff, prev_in;
   entry_type  prev_word_ff, prev_word_in;
   slot_type   idx_ff, idx_in;
   handle_type handle_ff, handle_in;
   key_type    key_ff, key_in;

   logic       rsp_strobe_ff, rsp_strobe_in;
   status_type rsp_status_ff, rsp_status_in;
   handle_type rsp_handle_ff, rsp_handle_in;
   count_type  rsp_count_ff, rsp_count_in;

   logic       ent_wr_en, ent_rd_en;
   slot_type   ent_wr_addr, ent_rd_addr;
   entry_type  ent_wr_data, ent_rd_data;
   logic       free_wr_en, free_rd_en;
   slot_type   free_wr_addr, free_rd_addr;
   slot_type   free_wr_data, free_rd_data;

   slot_type   new_slot;
   logic       walk_last;

   fkr_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   fkr_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (free_wr_en),
      .wr_addr (free_wr_addr),
      .wr_data (free_wr_data),
      .rd_en   (free_rd_en),
      .rd_addr (free_rd_addr),
      .rd_data (free_rd_data)
   );

   // A popped slot comes from the free stack; otherwise the next never-used slot is taken.
   assign new_slot  = pop_ff ? free_rd_data : hwm_ff[SLOT_BITS-1:0];
   assign walk_last = (COUNT_BITS'(idx_ff) + COUNT_BITS'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      sp_in         = sp_ff;
      hwm_in        = hwm_ff;
      pop_in        = pop_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_word_in  = prev_word_ff;
      idx_in        = idx_ff;
      handle_in     = handle_ff;
      key_in        = key_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;

      ent_wr_en    = 1'b0;
      ent_wr_addr  = slot_ff;
      ent_wr_data  = '{handle: handle_ff, key: key_ff, next: '0};
      ent_rd_en    = 1'b0;
      ent_rd_addr  = head_ff;
      free_wr_en   = 1'b0;
      free_wr_addr = sp_ff[SLOT_BITS-1:0];
      free_wr_data = cur_ff;
      free_rd_en   = 1'b0;
      free_rd_addr = slot_type'(sp_ff - COUNT_BITS'(1));

      unique case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               handle_in = req_entry_handle;
               key_in    = req_data_key;
               unique case (mode_type'(req_mode))
                  MODE_ADD: begin
                     if (count_ff == DEPTH_COUNT) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_FULL;
                        rsp_handle_in = '0;
                        rsp_count_in  = count_ff;
                     end else begin
                        pop_in     = (sp_ff != '0);
                        free_rd_en = (sp_ff != '0);
                        state_in   = S_ADD_PLACE;
                     end
                  end
                  MODE_TAKE, MODE_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NONE;
                        rsp_handle_in = '0;
                        rsp_count_in  = count_ff;
                     end else begin
                        ent_rd_en   = 1'b1;
                        ent_rd_addr = head_ff;
                        cur_in      = head_ff;
                        idx_in      = '0;
                        state_in    = (mode_type'(req_mode) == MODE_TAKE) ? S_TAKE : S_WALK;
                     end
                  end
                  MODE_FLUSH: begin
                     head_in       = '0;
                     tail_in       = '0;
                     count_in      = '0;
                     sp_in         = '0;
                     hwm_in        = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_DONE;
                     rsp_handle_in = '0;
                     rsp_count_in  = '0;
                  end
               endcase
            end
         end

         S_ADD_PLACE: begin
            slot_in     = new_slot;
            ent_wr_en   = 1'b1;
            ent_wr_addr = new_slot;
            ent_wr_data = '{handle: handle_ff, key: key_ff, next: '0};
            if (pop_ff) begin
               sp_in = sp_ff - COUNT_BITS'(1);
            end else begin
               hwm_in = hwm_ff + COUNT_BITS'(1);
            end
            if (count_ff == '0) begin
               head_in       = new_slot;
               tail_in       = new_slot;
               count_in      = COUNT_BITS'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_handle_in = '0;
               rsp_count_in  = COUNT_BITS'(1);
               state_in      = S_IDLE;
            end else begin
               // The tail entry is read back so that its link can be rewritten whole.
               ent_rd_en   = 1'b1;
               ent_rd_addr = tail_ff;
               state_in    = S_ADD_LINK;
            end
         end

         S_ADD_LINK: begin
            ent_wr_en     = 1'b1;
            ent_wr_addr   = tail_ff;
            ent_wr_data   = '{handle: ent_rd_data.handle, key: ent_rd_data.key, next: slot_ff};
            tail_in       = slot_ff;
            count_in      = count_ff + COUNT_BITS'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_handle_in = '0;
            rsp_count_in  = count_ff + COUNT_BITS'(1);
            state_in      = S_IDLE;
         end

         S_TAKE: begin
            free_wr_en    = 1'b1;
            free_wr_addr  = sp_ff[SLOT_BITS-1:0];
            free_wr_data  = cur_ff;
            sp_in         = sp_ff + COUNT_BITS'(1);
            count_in      = count_ff - COUNT_BITS'(1);
            if (count_ff == COUNT_BITS'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else begin
               head_in = ent_rd_data.next;
            end
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_handle_in = ent_rd_data.handle;
            rsp_count_in  = count_ff - COUNT_BITS'(1);
            state_in      = S_IDLE;
         end

         S_WALK: begin
            priority if (ent_rd_data.key == key_ff) begin
               if (idx_ff == '0) begin
                  head_in = ent_rd_data.next;
               end else begin
                  // Bridge the predecessor over the matching entry.
                  ent_wr_en   = 1'b1;
                  ent_wr_addr = prev_ff;
                  ent_wr_data = '{handle: prev_word_ff.handle, key: prev_word_ff.key,
                                  next: ent_rd_data.next};
                  if (walk_last) begin
                     tail_in = prev_ff;
                  end
               end
               if (count_ff == COUNT_BITS'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end
               free_wr_en    = 1'b1;
               free_wr_addr  = sp_ff[SLOT_BITS-1:0];
               free_wr_data  = cur_ff;
               sp_in         = sp_ff + COUNT_BITS'(1);
               count_in      = count_ff - COUNT_BITS'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_handle_in = ent_rd_data.handle;
               rsp_count_in  = count_ff - COUNT_BITS'(1);
               state_in      = S_IDLE;
            end else if (walk_last) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_NONE;
               rsp_handle_in = '0;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end else begin
               prev_in      = cur_ff;
               prev_word_in = ent_rd_data;
               cur_in       = ent_rd_data.next;
               idx_in       = idx_ff + SLOT_BITS'(1);
               ent_rd_en    = 1'b1;
               ent_rd_addr  = ent_rd_data.next;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pop_ff        <= pop_in;
      slot_ff       <= slot_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_word_ff  <= prev_word_in;
      idx_ff        <= idx_in;
      handle_ff     <= handle_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         sp_ff         <= '0;
         hwm_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         sp_ff         <= sp_in;
         hwm_ff        <= hwm_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_handle  = rsp_handle_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Between requests every slot is either held, on the free stack or above the high-water mark.
   a_slot_accounting : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (sp_ff + count_ff == hwm_ff))
      else $error("free slot accounting broken");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT)
      else $error("entry count above queue depth");

   a_empty_pointers : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with non-zero head or tail");

   a_result_has_request : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || req_start))
      else $error("result without a request");

   a_full_only_when_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> (rsp_entry_count == DEPTH_COUNT))
      else $error("full status with room left");

endmodule

// ----- test/fifo_with_keyed_removal_unit_tb.sv -----
// Self-checking testbench for the FIFO with keyed removal, with its own queue predictor.
`timescale 1ns / 1ps

module fifo_with_keyed_removal_unit_tb;
   import fkr_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TRAIL_CYCLES = 80;

   typedef struct {
      handle_type handle;
      key_type    key;
   } held_entry_type;

   typedef struct {
      status_type status;
      handle_type handle;
      count_type  count;
   } queue_answer_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_start;
   logic [1:0] req_mode;
   handle_type req_entry_handle;
   key_type    req_data_key;
   logic       busy;
   logic       rsp_strobe;
   logic [1:0] rsp_status;
   handle_type rsp_out_handle;
   count_type  rsp_entry_count;

   held_entry_type   held_entries[$];
   queue_answer_type pending_answers[$];
   queue_answer_type oldest;
   int               error_count = 0;
   int               cycle_count = 0;
   int               idle_percent = 0;

   fifo_with_keyed_removal_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_start        (req_start),
      .req_mode         (req_mode),
      .req_entry_handle (req_entry_handle),
      .req_data_key     (req_data_key),
      .busy             (busy),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_entry_count  (rsp_entry_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Applies one request to the predicted queue and files the answer it should give.
   function automatic void predict_answer(mode_type mode, handle_type handle, key_type key);
      queue_answer_type answer;
      held_entry_type   entry;
      int               hit;
      answer.status = ST_DONE;
      answer.handle = '0;
      hit = -1;
      case (mode)
         MODE_ADD: begin
            if (held_entries.size() >= QUEUE_DEPTH) begin
               answer.status = ST_FULL;
            end else begin
               entry.handle = handle;
               entry.key    = key;
               held_entries.push_back(entry);
            end
         end
         MODE_TAKE: begin
            if (held_entries.size() == 0) begin
               answer.status = ST_NONE;
            end else begin
               entry = held_entries.pop_front();
               answer.handle = entry.handle;
            end
         end
         MODE_REMOVE: begin
            for (int i = 0; i < held_entries.size() && hit < 0; i++) begin
               if (held_entries[i].key == key) hit = i;
            end
            if (hit < 0) begin
               answer.status = ST_NONE;
            end else begin
               answer.handle = held_entries[hit].handle;
               held_entries.delete(hit);
            end
         end
         default: held_entries.delete();
      endcase
      answer.count = count_type'(held_entries.size());
      pending_answers.push_back(answer);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) begin
            $error("answer with no request outstanding: status %0d, out_handle %0h",
                   rsp_status, rsp_out_handle);
            error_count++;
         end else begin
            oldest = pending_answers.pop_front();
            if (rsp_status !== oldest.status) begin
               $error("status mismatch: expected %0d, got %0d", oldest.status, rsp_status);
               error_count++;
            end
            if (rsp_out_handle !== oldest.handle) begin
               $error("out_handle mismatch: expected %0h, got %0h",
                      oldest.handle, rsp_out_handle);
               error_count++;
            end
            if (rsp_entry_count !== oldest.count) begin
               $error("entry_count mismatch: expected %0d, got %0d",
                      oldest.count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // Called at a rising edge. Start is left high after acceptance so that a following
   // request can go straight on; whoever pauses lowers it.
   task automatic idle_cycles(input int cycles);
      req_start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_request(input mode_type mode, input handle_type handle,
                               input key_type key);
      req_start        <= 1'b1;
      req_mode         <= mode;
      req_entry_handle <= handle;
      req_data_key     <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_answer(mode, handle, key);
      if ($urandom_range(99, 0) < idle_percent) idle_cycles($urandom_range(11, 1));
   endtask

   task automatic wait_drained();
      req_start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   function automatic key_type pick_key();
      if ($urandom_range(1, 0) == 0) return key_type'($urandom_range(15, 0));
      return key_type'($urandom);
   endfunction

   task automatic random_request(input int add_w, input int take_w, input int remove_w,
                                 input int flush_w);
      int       pick;
      mode_type mode;
      key_type  key;
      pick = $urandom_range(add_w + take_w + remove_w + flush_w - 1, 0);
      key  = pick_key();
      if (pick < add_w) begin
         mode = MODE_ADD;
      end else if (pick < add_w + take_w) begin
         mode = MODE_TAKE;
      end else if (pick < add_w + take_w + remove_w) begin
         mode = MODE_REMOVE;
         // Most searches aim at a key that is held, so the walk can stop at any depth.
         if (held_entries.size() > 0 && $urandom_range(9, 0) < 6)
            key = held_entries[$urandom_range(held_entries.size() - 1, 0)].key;
      end else begin
         mode = MODE_FLUSH;
      end
      send_request(mode, handle_type'($urandom), key);
   endtask

   task automatic test_empty_queue();
      send_request(MODE_TAKE, 16'h1234, 32'h0);
      send_request(MODE_REMOVE, 16'h0, 32'h0);
      send_request(MODE_REMOVE, 16'hffff, 32'hffff_ffff);
      send_request(MODE_FLUSH, 16'h0, 32'h0);
   endtask

   task automatic test_field_extremes();
      send_request(MODE_ADD, 16'h0000, 32'h0000_0000);
      send_request(MODE_ADD, 16'hffff, 32'hffff_ffff);
      send_request(MODE_ADD, 16'h5555, 32'h5555_5555);
      send_request(MODE_ADD, 16'haaaa, 32'haaaa_aaaa);
      send_request(MODE_TAKE, 16'h0, 32'h0);
      send_request(MODE_REMOVE, 16'h0, 32'hffff_ffff);
      send_request(MODE_REMOVE, 16'h0, 32'haaaa_aaaa);
      // The tail has just been removed, so this add must link behind the new tail.
      send_request(MODE_ADD, 16'h1234, 32'h0000_0000);
      send_request(MODE_TAKE, 16'h0, 32'h0);
      send_request(MODE_TAKE, 16'h0, 32'h0);
      send_request(MODE_TAKE, 16'h0, 32'h0);
   endtask

   task automatic test_duplicate_keys();
      send_request(MODE_ADD, 16'h0001, 32'd7);
      send_request(MODE_ADD, 16'h0002, 32'd9);
      send_request(MODE_ADD, 16'h0003, 32'd7);
      send_request(MODE_ADD, 16'h0004, 32'd7);
      send_request(MODE_REMOVE, 16'h0, 32'd7);
      send_request(MODE_REMOVE, 16'h0, 32'd7);
      send_request(MODE_REMOVE, 16'h0, 32'd12);
      send_request(MODE_REMOVE, 16'h0, 32'd7);
      send_request(MODE_ADD, 16'h0005, 32'd7);
      send_request(MODE_TAKE, 16'h0, 32'h0);
      send_request(MODE_ADD, 16'h0006, 32'd1);
      send_request(MODE_FLUSH, 16'h0, 32'h0);
   endtask

   task automatic test_full_queue();
      idle_percent = 15;
      while (held_entries.size() < QUEUE_DEPTH)
         send_request(MODE_ADD, handle_type'($urandom), key_type'($urandom));
      repeat (4) send_request(MODE_ADD, handle_type'($urandom), key_type'($urandom));
      send_request(MODE_REMOVE, 16'h0, held_entries[$].key);
      send_request(MODE_ADD, handle_type'($urandom), key_type'($urandom));
      repeat (60) random_request(50, 10, 40, 0);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 7; phase++) begin
         case ($urandom_range(2, 0))
            0:       idle_percent = 0;
            1:       idle_percent = 20;
            default: idle_percent = 50;
         endcase
         repeat (150)
            random_request($urandom_range(60, 20), $urandom_range(30, 5),
                           $urandom_range(40, 10), $urandom_range(2, 0));
         wait_drained();
      end
   endtask

   task automatic test_closing_burst();
      idle_percent = 0;
      repeat (150) random_request(40, 20, 35, 1);
   endtask

   initial begin
      reset            <= 1'b1;
      req_start        <= 1'b0;
      req_mode         <= MODE_ADD;
      req_entry_handle <= '0;
      req_data_key     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      idle_percent = 30;
      test_empty_queue();
      test_field_extremes();
      test_duplicate_keys();
      wait_drained();
      test_full_queue();
      test_random_traffic();
      test_closing_burst();

      wait_drained();
      repeat (TRAIL_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $error("%0d answers never arrived", pending_answers.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- fifo_with_keyed_removal_unit.f -----
hdl/fkr_pkg.sv
hdl/fkr_ram.sv
hdl/fifo_with_keyed_removal_unit.sv
test/fifo_with_keyed_removal_unit_tb.sv
